// File: rtl/core/wsbe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wall segment box extruder package
// Shared widths, a reset value and the vertex emission table.
// ----------------------------------------------------------------------------
package wsbe_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int DIR_WIDTH       = 24;
  localparam int THICK_WIDTH     = 16;
  localparam int HEIGHT_WIDTH    = 20;
  localparam int MINLEN_WIDTH    = 16;
  localparam int SHORT_WIDTH     = 16;
  localparam int QUOT_WIDTH      = 16;
  localparam int NUM_VERTS       = 36;
  localparam int VCNT_WIDTH      = $clog2(NUM_VERTS);

  localparam logic [MINLEN_WIDTH-1:0] MIN_LEN_RESET = MINLEN_WIDTH'(3);

  // corner index in [1:0], top flag in [2]
  localparam logic [2:0] VERT_ORDER [NUM_VERTS] = '{
    3'd4, 3'd5, 3'd6, 3'd4, 3'd6, 3'd7,
    3'd0, 3'd2, 3'd1, 3'd0, 3'd3, 3'd2,
    3'd0, 3'd1, 3'd5, 3'd0, 3'd5, 3'd4,
    3'd1, 3'd2, 3'd6, 3'd1, 3'd6, 3'd5,
    3'd2, 3'd3, 3'd7, 3'd2, 3'd7, 3'd6,
    3'd3, 3'd0, 3'd4, 3'd3, 3'd4, 3'd7
  };

endpackage
`default_nettype wire

// File: rtl/core/wsbe_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wall segment box extruder channels
// Segment input, vertex output and configuration write channels.
// ----------------------------------------------------------------------------
interface wsbe_seg_if #(
  parameter int CW = wsbe_pkg::COORD_WIDTH_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic signed [CW-1:0]                  start_x;
  logic signed [CW-1:0]                  start_y;
  logic signed [CW-1:0]                  end_x;
  logic signed [CW-1:0]                  end_y;
  logic [wsbe_pkg::THICK_WIDTH-1:0]      wall_thickness;
  logic [wsbe_pkg::HEIGHT_WIDTH-1:0]     wall_height;

  modport source (output valid, start_x, start_y, end_x, end_y, wall_thickness,
                  wall_height, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, wall_thickness,
                  wall_height, output ready);
endinterface

interface wsbe_vtx_if #(
  parameter int CW = wsbe_pkg::COORD_WIDTH_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic signed [CW-1:0]                  vert_x;
  logic [wsbe_pkg::HEIGHT_WIDTH-1:0]     vert_y;
  logic signed [CW-1:0]                  vert_z;
  logic                                  last_vertex;

  modport source (output valid, vert_x, vert_y, vert_z, last_vertex, input ready);
  modport sink   (input valid, vert_x, vert_y, vert_z, last_vertex, output ready);
endinterface

interface wsbe_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [wsbe_pkg::MINLEN_WIDTH-1:0]     min_length_sq;

  modport source (output valid, min_length_sq, input ready);
  modport sink   (input valid, min_length_sq, output ready);
endinterface
`default_nettype wire

// File: rtl/core/wall_segment_box_extruder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wall segment box extruder core
// Extrudes a 2D wall segment into 36 triangle vertices of a closed box.
// ----------------------------------------------------------------------------
// Each segment passes the difference, square and length stages, the bit-pair
// square root and the dual divider; the emitter then gives one vertex per cycle
// unless out_vtx.ready holds it, while the root and divider take later segments.
// Reset: synchronous active low; clears all valid flags and counters and loads
// min_length_sq with 3. Short segments are dropped on entry to the third stage.
module wall_segment_box_extruder_core #(
  parameter int COORD_WIDTH = wsbe_pkg::COORD_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  wsbe_seg_if.sink   in_seg,
  wsbe_vtx_if.source out_vtx,
  wsbe_cfg_if.sink   cfg_wr
);
  import wsbe_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int DSH   = (CW > DIR_WIDTH) ? CW - DIR_WIDTH : 0;
  localparam int UW    = DIR_WIDTH;
  localparam int SQW   = 2 * UW;
  localparam int LW    = SQW + 1;
  localparam int SW    = (LW + 12 + 1) / 2;
  localparam int RADW  = 2 * SW;
  localparam int RW    = SW + 2;
  localparam int PW    = UW + THICK_WIDTH;
  localparam int N2W   = PW + 7;
  localparam int DVW   = SW + 1;
  localparam int QW    = QUOT_WIDTH;
  localparam int OW    = QW + 2;
  localparam int EW    = CW + 2;
  localparam int SCW   = $clog2(SW + 1);
  localparam int DCW   = $clog2(QW + 1);

  typedef struct packed {
    logic signed [CW-1:0]      sx;
    logic signed [CW-1:0]      sy;
    logic signed [CW-1:0]      ex;
    logic signed [CW-1:0]      ey;
    logic [THICK_WIDTH-1:0]    t;
    logic [HEIGHT_WIDTH-1:0]   h;
    logic                      dxn;
    logic                      dyn;
  } geo_t;

  function automatic logic signed [CW-1:0] sat_c(input logic signed [EW-1:0] v);
    logic signed [CW-1:0] res;
    if ((v[EW-1:CW-1] == '0) || (v[EW-1:CW-1] == '1)) begin
      res = v[CW-1:0];
    end else if (v[EW-1]) begin
      res = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res = {1'b0, {(CW-1){1'b1}}};
    end
    return res;
  endfunction

  // configuration
  logic [MINLEN_WIDTH-1:0] min_len_r;
  assign cfg_wr.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
    end else if (cfg_wr.valid) begin
      min_len_r <= cfg_wr.min_length_sq;
    end
  end

  // stage 1: differences and magnitudes
  logic            s1_valid_r;
  geo_t            s1_geo_r;
  logic [CW-1:0]   s1_ax_r, s1_ay_r;
  logic            s2_ready, s1_adv;
  logic signed [CW:0] dx, dy;
  logic [CW:0]     axw, ayw;
  geo_t            in_geo;

  assign dx = {in_seg.end_x[CW-1], in_seg.end_x} - {in_seg.start_x[CW-1], in_seg.start_x};
  assign dy = {in_seg.end_y[CW-1], in_seg.end_y} - {in_seg.start_y[CW-1], in_seg.start_y};
  assign axw = dx[CW] ? -dx : dx;
  assign ayw = dy[CW] ? -dy : dy;

  always_comb begin
    in_geo.sx  = in_seg.start_x;
    in_geo.sy  = in_seg.start_y;
    in_geo.ex  = in_seg.end_x;
    in_geo.ey  = in_seg.end_y;
    in_geo.t   = in_seg.wall_thickness;
    in_geo.h   = in_seg.wall_height;
    in_geo.dxn = dx[CW];
    in_geo.dyn = dy[CW];
  end

  assign s1_adv       = !s1_valid_r || s2_ready;
  assign in_seg.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_seg.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (s1_adv && in_seg.valid) begin
      s1_geo_r <= in_geo;
      s1_ax_r  <= axw[CW-1:0];
      s1_ay_r  <= ayw[CW-1:0];
    end
  end

  // stage 2: squares
  logic                   s2_valid_r;
  geo_t                   s2_geo_r;
  logic [UW-1:0]          s2_ux_r, s2_uy_r;
  logic [SQW-1:0]         s2_uxx_r, s2_uyy_r;
  logic                   s2_small_r;
  logic [2*SHORT_WIDTH-1:0] s2_sqa_r, s2_sqb_r;
  logic [CW-1:0]          ax_sh, ay_sh;
  logic [UW-1:0]          ux, uy;
  logic                   s3_ready;

  assign ax_sh    = s1_ax_r >> DSH;
  assign ay_sh    = s1_ay_r >> DSH;
  assign ux       = UW'(ax_sh);
  assign uy       = UW'(ay_sh);
  assign s2_ready = !s2_valid_r || s3_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_geo_r   <= s1_geo_r;
      s2_ux_r    <= ux;
      s2_uy_r    <= uy;
      s2_uxx_r   <= ux * ux;
      s2_uyy_r   <= uy * uy;
      s2_small_r <= ((s1_ax_r >> SHORT_WIDTH) == '0) && ((s1_ay_r >> SHORT_WIDTH) == '0);
      s2_sqa_r   <= s1_ax_r[SHORT_WIDTH-1:0] * s1_ax_r[SHORT_WIDTH-1:0];
      s2_sqb_r   <= s1_ay_r[SHORT_WIDTH-1:0] * s1_ay_r[SHORT_WIDTH-1:0];
    end
  end

  // stage 3: length square, short test, thickness products
  logic               s3_valid_r;
  geo_t               s3_geo_r;
  logic [LW-1:0]      s3_len_r;
  logic [PW-1:0]      s3_mox_r, s3_moy_r;
  logic [2*SHORT_WIDTH:0] short_sum;
  logic               is_short;
  logic               sq_ready;

  assign short_sum = {1'b0, s2_sqa_r} + {1'b0, s2_sqb_r};
  assign is_short  = s2_small_r && (short_sum < (2*SHORT_WIDTH+1)'(min_len_r));
  assign s3_ready  = !s3_valid_r || sq_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r && !is_short;
    end
  end
  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      s3_geo_r <= s2_geo_r;
      s3_len_r <= {1'b0, s2_uxx_r} + {1'b0, s2_uyy_r};
      s3_mox_r <= s2_uy_r * s2_geo_r.t;
      s3_moy_r <= s2_ux_r * s2_geo_r.t;
    end
  end

  // square root: one result bit per cycle
  logic            sq_valid_r;
  logic [SCW-1:0]  sq_cnt_r;
  logic [RADW-1:0] sq_rad_r;
  logic [RW-1:0]   sq_rem_r;
  logic [SW-1:0]   sq_root_r;
  geo_t            sq_geo_r;
  logic [PW-1:0]   sq_mox_r, sq_moy_r;
  logic            sq_done, sq_load, dv_ready;
  logic [RW-1:0]   sq_t, sq_trial;
  logic            sq_ge;

  assign sq_done  = sq_valid_r && (sq_cnt_r == '0);
  assign sq_ready = !sq_valid_r || (sq_done && dv_ready);
  assign sq_load  = sq_ready && s3_valid_r;
  assign sq_t     = {sq_rem_r[RW-3:0], sq_rad_r[RADW-1:RADW-2]};
  assign sq_trial = {sq_root_r, 2'b01};
  assign sq_ge    = sq_t >= sq_trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_valid_r <= 1'b0;
      sq_cnt_r   <= '0;
    end else if (sq_load) begin
      sq_valid_r <= 1'b1;
      sq_cnt_r   <= SCW'(SW);
    end else if (sq_ready) begin
      sq_valid_r <= 1'b0;
    end else if (sq_cnt_r != '0) begin
      sq_cnt_r <= sq_cnt_r - 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (sq_load) begin
      sq_rad_r  <= RADW'({s3_len_r, 12'b0});
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      sq_geo_r  <= s3_geo_r;
      sq_mox_r  <= s3_mox_r;
      sq_moy_r  <= s3_moy_r;
    end else if (sq_valid_r && (sq_cnt_r != '0)) begin
      sq_rad_r  <= {sq_rad_r[RADW-3:0], 2'b00};
      sq_rem_r  <= sq_ge ? (sq_t - sq_trial) : sq_t;
      sq_root_r <= {sq_root_r[SW-2:0], sq_ge};
    end
  end

  // rounding dividers for both offset components
  logic            dv_valid_r;
  logic [DCW-1:0]  dv_cnt_r;
  logic            dv_zero_r;
  logic [DVW-1:0]  dv_dvs_r, dv_remx_r, dv_remy_r;
  logic [QW-1:0]   dv_qx_r, dv_qy_r;
  geo_t            dv_geo_r;
  logic            dv_done, dv_load, em_ready;
  logic [N2W-1:0]  num_x, num_y;
  logic [DVW:0]    dv_tx, dv_ty;
  logic            dv_gex, dv_gey;

  assign num_x    = {1'b0, sq_mox_r, 6'b0} + N2W'(sq_root_r);
  assign num_y    = {1'b0, sq_moy_r, 6'b0} + N2W'(sq_root_r);
  assign dv_done  = dv_valid_r && (dv_cnt_r == '0);
  assign dv_ready = !dv_valid_r || (dv_done && em_ready);
  assign dv_load  = dv_ready && sq_done;
  assign dv_tx    = {dv_remx_r, dv_qx_r[QW-1]};
  assign dv_ty    = {dv_remy_r, dv_qy_r[QW-1]};
  assign dv_gex   = dv_tx >= {1'b0, dv_dvs_r};
  assign dv_gey   = dv_ty >= {1'b0, dv_dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r <= 1'b0;
      dv_cnt_r   <= '0;
    end else if (dv_load) begin
      dv_valid_r <= 1'b1;
      dv_cnt_r   <= DCW'(QW);
    end else if (dv_ready) begin
      dv_valid_r <= 1'b0;
    end else if (dv_cnt_r != '0) begin
      dv_cnt_r <= dv_cnt_r - 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (dv_load) begin
      dv_zero_r <= (sq_root_r == '0);
      dv_dvs_r  <= {sq_root_r, 1'b0};
      dv_remx_r <= DVW'(num_x >> QW);
      dv_remy_r <= DVW'(num_y >> QW);
      dv_qx_r   <= num_x[QW-1:0];
      dv_qy_r   <= num_y[QW-1:0];
      dv_geo_r  <= sq_geo_r;
    end else if (dv_valid_r && (dv_cnt_r != '0)) begin
      dv_remx_r <= dv_gex ? DVW'(dv_tx - {1'b0, dv_dvs_r}) : DVW'(dv_tx);
      dv_remy_r <= dv_gey ? DVW'(dv_ty - {1'b0, dv_dvs_r}) : DVW'(dv_ty);
      dv_qx_r   <= {dv_qx_r[QW-2:0], dv_gex};
      dv_qy_r   <= {dv_qy_r[QW-2:0], dv_gey};
    end
  end

  // corners
  logic [QW-1:0]        mx, my;
  logic signed [OW-1:0] offx, offy;
  logic signed [EW-1:0] ox, oy, sxe, sye, exe, eye;
  logic signed [CW-1:0] cx [4];
  logic signed [CW-1:0] cz [4];

  assign mx   = dv_zero_r ? '0 : dv_qx_r;
  assign my   = dv_zero_r ? '0 : dv_qy_r;
  assign offx = dv_geo_r.dyn ? -$signed({2'b00, mx}) : $signed({2'b00, mx});
  assign offy = dv_geo_r.dxn ? $signed({2'b00, my}) : -$signed({2'b00, my});
  assign ox   = {{(EW-OW){offx[OW-1]}}, offx};
  assign oy   = {{(EW-OW){offy[OW-1]}}, offy};
  assign sxe  = {{2{dv_geo_r.sx[CW-1]}}, dv_geo_r.sx};
  assign sye  = {{2{dv_geo_r.sy[CW-1]}}, dv_geo_r.sy};
  assign exe  = {{2{dv_geo_r.ex[CW-1]}}, dv_geo_r.ex};
  assign eye  = {{2{dv_geo_r.ey[CW-1]}}, dv_geo_r.ey};

  always_comb begin
    cx[0] = sat_c(sxe + ox);
    cx[1] = sat_c(exe + ox);
    cx[2] = sat_c(exe - ox);
    cx[3] = sat_c(sxe - ox);
    cz[0] = sat_c(-(sye + oy));
    cz[1] = sat_c(-(eye + oy));
    cz[2] = sat_c(-(eye - oy));
    cz[3] = sat_c(-(sye - oy));
  end

  // vertex emitter and output register
  logic                    em_valid_r;
  logic [VCNT_WIDTH-1:0]   em_cnt_r;
  logic signed [CW-1:0]    em_cx_r [4];
  logic signed [CW-1:0]    em_cz_r [4];
  logic [HEIGHT_WIDTH-1:0] em_h_r;
  logic                    out_valid_r, out_last_r, out_load, em_last;
  logic signed [CW-1:0]    out_x_r, out_z_r;
  logic [HEIGHT_WIDTH-1:0] out_y_r;
  logic [2:0]              ventry;

  assign ventry   = VERT_ORDER[em_cnt_r];
  assign em_last  = (em_cnt_r == VCNT_WIDTH'(NUM_VERTS - 1));
  assign out_load = em_valid_r && (!out_valid_r || out_vtx.ready);
  assign em_ready = !em_valid_r || (out_load && em_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
      em_cnt_r   <= '0;
    end else begin
      if (em_ready) begin
        em_valid_r <= dv_done;
        em_cnt_r   <= '0;
      end else if (out_load) begin
        em_cnt_r <= em_cnt_r + 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (em_ready && dv_done) begin
      em_cx_r <= cx;
      em_cz_r <= cz;
      em_h_r  <= dv_geo_r.h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_vtx.ready) begin
      out_valid_r <= em_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_x_r    <= em_cx_r[ventry[1:0]];
      out_z_r    <= em_cz_r[ventry[1:0]];
      out_y_r    <= ventry[2] ? em_h_r : '0;
      out_last_r <= em_last;
    end
  end

  assign out_vtx.valid       = out_valid_r;
  assign out_vtx.vert_x      = out_x_r;
  assign out_vtx.vert_y      = out_y_r;
  assign out_vtx.vert_z      = out_z_r;
  assign out_vtx.last_vertex = out_last_r;

`ifndef ASSERT_OFF
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> (mx <= QW'(1 << (QW - 1))) && (my <= QW'(1 << (QW - 1))))
    else $error("offset quotient out of range");

  a_em_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(em_valid_r) |-> $past(out_load && em_last))
    else $error("emitter released a wall before its last vertex");

  a_out_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_vtx.ready && out_last_r))
    else $error("vertex stream stopped inside a wall");
`endif

endmodule
`default_nettype wire
